// ===== sv/mbc1_pkg.sv =====
// MBC1 bank controller: shared types, codes and address constants.
// Used by mbc1_bank_controller_core; no dependencies.
`default_nettype none

package mbc1_pkg;

    // item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_LOAD  = 2'd2
    } kind_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MBC1_ENABLED    = 2'd0,
        CFG_BATTERY_PRESENT = 2'd1,
        CFG_RAM_BANK_COUNT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    // where a pending read takes its byte from
    typedef enum logic [1:0] {
        SRC_ROM,
        SRC_RAM,
        SRC_OPEN
    } src_t;

    localparam int          RAM_BANK_AW   = 13;      // 8 KiB per RAM bank
    localparam int          OFS_W         = 20;      // widest banked ROM offset
    localparam logic [15:0] REGION_MASK   = 16'hE000;
    localparam logic [15:0] REGION_RAMEN  = 16'h0000;
    localparam logic [15:0] REGION_ROMBNK = 16'h2000;
    localparam logic [15:0] REGION_RAMBNK = 16'h4000;
    localparam logic [15:0] REGION_MODE   = 16'h6000;
    localparam logic [15:0] REGION_XRAM   = 16'hA000;
    localparam logic [15:0] WINDOW_BASE   = 16'h4000;
    localparam logic [3:0]  RAM_EN_KEY    = 4'hA;
    localparam logic [4:0]  ROM_BANK_MASK = 5'b11111;
    localparam logic [7:0]  OPEN_BUS      = 8'hFF;

endpackage

`default_nettype wire

// ===== sv/mbc1_ram.sv =====
// Generic single-port synchronous RAM, read data registered (read-first).
// No dependencies; used for the ROM and external RAM stores.
`default_nettype none

module mbc1_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== sv/mbc1_bank_controller_core.sv =====
// MBC1 cartridge bank controller core. Reads, writes and ROM preload words in,
// one result word out per item. Depends on mbc1_pkg and mbc1_ram.
// Bus reads pass the ROM/RAM read register, then the output register; writes,
// preloads and unknown kinds load it directly. Throughput: non-read items one
// per cycle while the output slot is free; input waits while a read is pending.
// Reset: control state clears at once; then a clearing pass zeroes all external
// NUM_EXT_BANKS*8192 RAM bytes, with s_tready low (config writes still taken).
`default_nettype none

module mbc1_bank_controller_core #(
    parameter int ROM_BYTES     = 131072,   // power of two, 32 KiB .. 512 KiB
    parameter int NUM_EXT_BANKS = 4         // 1 .. 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // address[15:0], data[23:16], load_address[40:24], 0
    input  wire logic [1:0]  s_tuser,   // kind[1:0]

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // read_data[7:0], save_dirty[8], 0

    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [4:0]  cfg_data
);

    localparam int ROM_AW    = $clog2(ROM_BYTES);
    localparam int RAM_DEPTH = NUM_EXT_BANKS * (2 ** mbc1_pkg::RAM_BANK_AW);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // ------------------------------------------------------------------
    // input word unpacking
    // ------------------------------------------------------------------
    mbc1_pkg::kind_t kind;
    logic [15:0]     address;
    logic [7:0]      data;
    logic [16:0]     load_address;

    assign kind         = mbc1_pkg::kind_t'(s_tuser);
    assign address      = s_tdata[15:0];
    assign data         = s_tdata[23:16];
    assign load_address = s_tdata[40:24];

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    mbc1_pkg::state_t state_reg, state_next;
    mbc1_pkg::src_t   src_reg, src_next;
    logic [RAM_AW-1:0] clr_addr_reg, clr_addr_next;

    // configuration
    logic       mbc1_enabled_reg;
    logic       battery_present_reg;
    logic [4:0] ram_bank_count_reg;

    // bank state
    logic       ram_enable_reg, ram_enable_next;
    logic [4:0] rom_bank_reg, rom_bank_next;
    logic [1:0] ram_bank_select_reg, ram_bank_select_next;
    logic       banking_mode_reg, banking_mode_next;
    logic [1:0] active_ram_bank_reg, active_ram_bank_next;
    logic       dirty_reg, dirty_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [7:0] read_data_reg, read_data_next;
    logic       save_dirty_reg, save_dirty_next;

    // memory ports
    logic              rom_we;
    logic [ROM_AW-1:0] rom_addr;
    logic [7:0]        rom_rdata;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // ------------------------------------------------------------------
    // address decode
    // ------------------------------------------------------------------
    logic [15:0]              region;
    logic                     accept;
    logic                     bank_present;
    logic                     xram_ok;
    logic [mbc1_pkg::OFS_W-1:0] flat_ofs;
    logic [mbc1_pkg::OFS_W-1:0] window_ofs;
    logic [mbc1_pkg::OFS_W-1:0] load_ofs;
    logic [14:0]              ram_index;
    logic                     flat_read;
    logic                     xram_region;

    assign region      = address & mbc1_pkg::REGION_MASK;
    assign accept      = s_tvalid && s_tready;
    assign xram_region = (region == mbc1_pkg::REGION_XRAM);

    // bank must be below both the fitted count and the built depth
    assign bank_present = ({3'd0, active_ram_bank_reg} < ram_bank_count_reg)
                       && ({1'b0, active_ram_bank_reg} < 3'(NUM_EXT_BANKS));
    assign xram_ok      = ram_enable_reg && bank_present;

    // flat map below 0x4000 or when banking is off; window is rom_bank*16K + (a-16K)
    assign flat_read  = (address < mbc1_pkg::WINDOW_BASE) || !mbc1_enabled_reg;
    assign flat_ofs   = {4'd0, address};
    assign window_ofs = {1'b0, rom_bank_reg, 14'd0}
                      + {4'd0, address - mbc1_pkg::WINDOW_BASE};
    assign load_ofs   = {3'd0, load_address};
    assign ram_index  = {active_ram_bank_reg, address[mbc1_pkg::RAM_BANK_AW-1:0]};

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    always_comb
    begin
        rom_we = accept && (kind == mbc1_pkg::KIND_LOAD);
        if (kind == mbc1_pkg::KIND_LOAD)
        begin
            rom_addr = load_ofs[ROM_AW-1:0];
        end
        else if (flat_read)
        begin
            rom_addr = flat_ofs[ROM_AW-1:0];
        end
        else
        begin
            rom_addr = window_ofs[ROM_AW-1:0];
        end

        // clearing pass owns the RAM port until it finishes
        if (state_reg == mbc1_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = 8'd0;
        end
        else
        begin
            ram_we    = accept && (kind == mbc1_pkg::KIND_WRITE) && mbc1_enabled_reg
                     && xram_region && xram_ok;
            ram_addr  = ram_index[RAM_AW-1:0];
            ram_wdata = data;
        end
    end

    mbc1_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .addr  (rom_addr),
        .wdata (data),
        .rdata (rom_rdata)
    );

    mbc1_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_xram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // configuration port: always ready; unenforced by the block, the user must write it only while idle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbc1_enabled_reg    <= 1'b0;
            battery_present_reg <= 1'b0;
            ram_bank_count_reg  <= 5'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (mbc1_pkg::cfg_idx_t'(cfg_index))
                mbc1_pkg::CFG_MBC1_ENABLED:    mbc1_enabled_reg    <= cfg_data[0];
                mbc1_pkg::CFG_BATTERY_PRESENT: battery_present_reg <= cfg_data[0];
                mbc1_pkg::CFG_RAM_BANK_COUNT:  ram_bank_count_reg  <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= mbc1_pkg::ST_CLEAR;
            src_reg             <= mbc1_pkg::SRC_ROM;
            clr_addr_reg        <= '0;
            ram_enable_reg      <= 1'b0;
            rom_bank_reg        <= 5'd1;
            ram_bank_select_reg <= 2'd0;
            banking_mode_reg    <= 1'b0;
            active_ram_bank_reg <= 2'd0;
            dirty_reg           <= 1'b0;
            m_valid_reg         <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            src_reg             <= src_next;
            clr_addr_reg        <= clr_addr_next;
            ram_enable_reg      <= ram_enable_next;
            rom_bank_reg        <= rom_bank_next;
            ram_bank_select_reg <= ram_bank_select_next;
            banking_mode_reg    <= banking_mode_next;
            active_ram_bank_reg <= active_ram_bank_next;
            dirty_reg           <= dirty_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        read_data_reg  <= read_data_next;
        save_dirty_reg <= save_dirty_next;
    end

    // ------------------------------------------------------------------
    // next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next           = state_reg;
        src_next             = src_reg;
        clr_addr_next        = clr_addr_reg;
        ram_enable_next      = ram_enable_reg;
        rom_bank_next        = rom_bank_reg;
        ram_bank_select_next = ram_bank_select_reg;
        banking_mode_next    = banking_mode_reg;
        active_ram_bank_next = active_ram_bank_reg;
        dirty_next           = dirty_reg;
        read_data_next       = read_data_reg;
        save_dirty_next      = save_dirty_reg;
        s_tready             = 1'b0;

        // output word leaves when taken
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            mbc1_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1))
                begin
                    state_next = mbc1_pkg::ST_IDLE;
                end
            end

            mbc1_pkg::ST_IDLE:
            begin
                // output slot is free now or frees at this edge
                s_tready = !m_valid_reg || m_tready;
                if (accept)
                begin
                    if (kind == mbc1_pkg::KIND_READ)
                    begin
                        state_next = mbc1_pkg::ST_READ;
                        if (flat_read || !xram_region)
                        begin
                            src_next = mbc1_pkg::SRC_ROM;
                        end
                        else if (xram_ok)
                        begin
                            src_next = mbc1_pkg::SRC_RAM;
                        end
                        else
                        begin
                            src_next = mbc1_pkg::SRC_OPEN;
                        end
                    end
                    else
                    begin
                        if ((kind == mbc1_pkg::KIND_WRITE) && mbc1_enabled_reg)
                        begin
                            if (region == mbc1_pkg::REGION_RAMEN)
                            begin
                                ram_enable_next = (data[3:0] == mbc1_pkg::RAM_EN_KEY);
                            end
                            if (region == mbc1_pkg::REGION_ROMBNK)
                            begin
                                // bank 0 maps to 1 before masking
                                rom_bank_next = (data == 8'd0) ? 5'd1
                                              : (data[4:0] & mbc1_pkg::ROM_BANK_MASK);
                            end
                            if (region == mbc1_pkg::REGION_RAMBNK)
                            begin
                                ram_bank_select_next = data[1:0];
                                if (banking_mode_reg)
                                begin
                                    active_ram_bank_next = data[1:0];
                                end
                            end
                            if (region == mbc1_pkg::REGION_MODE)
                            begin
                                banking_mode_next = data[0];
                                if (data[0])
                                begin
                                    active_ram_bank_next = ram_bank_select_reg;
                                end
                            end
                            if (xram_region && xram_ok && battery_present_reg)
                            begin
                                dirty_next = 1'b1;
                            end
                        end
                        // writes, preloads and unknown kinds answer at once
                        m_valid_next    = 1'b1;
                        read_data_next  = 8'd0;
                        save_dirty_next = dirty_next;
                    end
                end
            end

            mbc1_pkg::ST_READ:
            begin
                state_next      = mbc1_pkg::ST_IDLE;
                m_valid_next    = 1'b1;
                save_dirty_next = dirty_reg;
                case (src_reg)
                    mbc1_pkg::SRC_ROM: read_data_next = rom_rdata;
                    mbc1_pkg::SRC_RAM: read_data_next = ram_rdata;
                    default:           read_data_next = mbc1_pkg::OPEN_BUS;
                endcase
            end

            default:
            begin
                state_next = mbc1_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, save_dirty_reg, read_data_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == mbc1_pkg::KIND_READ)
        |=> (state_reg == mbc1_pkg::ST_READ) && !m_valid_reg)
        else $error("read accepted without entering the memory read cycle");

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbc1_pkg::ST_READ) |=> m_valid_reg && (state_reg == mbc1_pkg::ST_IDLE))
        else $error("memory read cycle did not load the output register");

    a_no_ram_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbc1_pkg::ST_READ) |-> !ram_we && !rom_we)
        else $error("memory write during a pending read");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(dirty_reg))
        else $error("dirty flag cleared without reset");

    a_dirty_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dirty_reg) |-> $past(ram_we) && $past(state_reg == mbc1_pkg::ST_IDLE)
                             && $past(battery_present_reg))
        else $error("dirty flag set without a battery RAM write");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for mbc1_bank_controller_core: random and directed bus items,
// an in-bench cartridge predictor and in-order result checks.
// Depends on mbc1_pkg and the RTL of mbc1_bank_controller_core.

module testbench;

    localparam int         ROM_LEN      = 131072;
    localparam int         XRAM_LEN     = 4 * 8192;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int         IDLE_PCT     = 36;
    localparam int         PHASE_ITEMS  = 160;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 4;

    typedef struct packed {
        logic [7:0] read_data;
        logic       save_dirty;
    } result_t;

    // Cartridge predictor: mirrors mapper state and memories, queues expected words.
    class cart_predictor;
        logic [7:0] rom [ROM_LEN];
        bit         rom_loaded [ROM_LEN];
        logic [7:0] ram [XRAM_LEN];
        logic       ram_en;
        logic [4:0] rom_bank;
        logic [1:0] bank_sel;
        logic       mode;
        logic [1:0] active_bank;
        logic       dirty;
        logic       mbc1_on;
        logic       battery;
        logic [4:0] bank_count;
        result_t    expected_q [$];
        int         errors;

        function new();
            foreach (ram[i])
                ram[i] = 8'h00;
            ram_en      = 1'b0;
            rom_bank    = 5'd1;
            bank_sel    = 2'd0;
            mode        = 1'b0;
            active_bank = 2'd0;
            dirty       = 1'b0;
            mbc1_on     = 1'b0;
            battery     = 1'b0;
            bank_count  = 5'd0;
            errors      = 0;
        endfunction

        function void set_reg(mbc1_pkg::cfg_idx_t idx, logic [4:0] v);
            case (idx)
                mbc1_pkg::CFG_MBC1_ENABLED:    mbc1_on = v[0];
                mbc1_pkg::CFG_BATTERY_PRESENT: battery = v[0];
                mbc1_pkg::CFG_RAM_BANK_COUNT:  bank_count = v;
                default: ;
            endcase
        endfunction

        function bit bank_fitted();
            return {3'b000, active_bank} < bank_count;
        endfunction

        // ROM byte offset a read maps to, or -1 for the external RAM window
        function int rom_offset(logic [15:0] a);
            if (a < mbc1_pkg::WINDOW_BASE || !mbc1_on)
                return int'(a);
            if ((a & mbc1_pkg::REGION_MASK) == mbc1_pkg::REGION_XRAM)
                return -1;
            return (int'(rom_bank) * int'(mbc1_pkg::WINDOW_BASE) + int'(a)
                    - int'(mbc1_pkg::WINDOW_BASE)) % ROM_LEN;
        endfunction

        function logic [7:0] bus_read(logic [15:0] a);
            int ofs;
            ofs = rom_offset(a);
            if (ofs >= 0)
                return rom[ofs];
            if (!ram_en || !bank_fitted())
                return mbc1_pkg::OPEN_BUS;
            return ram[{active_bank, a[12:0]}];
        endfunction

        function void bus_write(logic [15:0] a, logic [7:0] v);
            logic [15:0] region;
            if (!mbc1_on)
                return;
            region = a & mbc1_pkg::REGION_MASK;
            if (a < mbc1_pkg::REGION_ROMBNK)
                ram_en = (v[3:0] == mbc1_pkg::RAM_EN_KEY);
            case (region)
                mbc1_pkg::REGION_ROMBNK:
                    rom_bank = (v == 8'd0) ? 5'd1 : (v[4:0] & mbc1_pkg::ROM_BANK_MASK);
                mbc1_pkg::REGION_RAMBNK:
                begin
                    bank_sel = v[1:0];
                    if (mode)
                        active_bank = bank_sel;
                end
                mbc1_pkg::REGION_MODE:
                begin
                    mode = v[0];
                    if (mode)
                        active_bank = bank_sel;
                end
                mbc1_pkg::REGION_XRAM:
                begin
                    if (ram_en && bank_fitted())
                    begin
                        ram[{active_bank, a[12:0]}] = v;
                        if (battery)
                            dirty = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_item(logic [1:0] kind, logic [15:0] a, logic [7:0] v,
                                logic [16:0] la);
            result_t r;
            r.read_data = 8'h00;
            case (kind)
                mbc1_pkg::KIND_READ:  r.read_data = bus_read(a);
                mbc1_pkg::KIND_WRITE: bus_write(a, v);
                mbc1_pkg::KIND_LOAD:
                begin
                    rom[la]        = v;
                    rom_loaded[la] = 1'b1;
                end
                default: ;
            endcase
            r.save_dirty = dirty;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] rd, logic sd);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: read_data %h save_dirty %b", rd, sd);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (rd !== e.read_data)
            begin
                $error("read_data: expected %h, actual %h", e.read_data, rd);
                errors++;
            end
            if (sd !== e.save_dirty)
            begin
                $error("save_dirty: expected %b, actual %b", e.save_dirty, sd);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // address[15:0], data[23:16], load_address[40:24], 0
    logic [1:0]  s_tuser   = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // read_data[7:0], save_dirty[8], 0
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [4:0]  cfg_data  = '0;

    bit            no_idle  = 1'b0;
    bit            hold_req = 1'b0;
    cart_predictor cart;

    mbc1_bank_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: random backpressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            cart.check_result(m_tdata[7:0], m_tdata[8]);
    end

    initial
    begin
        #3200000;
        $display("mbc1_bank_controller_core test failed");
        $finish;
    end

    function bit idle_now();
        return !no_idle && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // called at a falling edge; leaves tvalid high for a following word
    task automatic send_item(logic [1:0] kind, logic [15:0] a, logic [7:0] v,
                             logic [16:0] la);
        while (idle_now())
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {7'b0, la, v, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cart.note_item(kind, a, v, la);
        @(negedge clk);
    endtask

    // reads of ROM bytes never loaded are out of contract: load them first
    task automatic do_item(logic [1:0] kind, logic [15:0] a, logic [7:0] v,
                           logic [16:0] la);
        int ofs;
        if (kind == mbc1_pkg::KIND_READ)
        begin
            ofs = cart.rom_offset(a);
            if (ofs >= 0 && !cart.rom_loaded[ofs])
                send_item(mbc1_pkg::KIND_LOAD, 16'($urandom), 8'($urandom), 17'(ofs));
        end
        send_item(kind, a, v, la);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (cart.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(mbc1_pkg::cfg_idx_t idx, logic [4:0] v);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cart.set_reg(idx, v);
        @(negedge clk);
    endtask

    task automatic configure(logic mbc1, logic batt, logic [4:0] banks);
        settle();
        write_reg(mbc1_pkg::CFG_MBC1_ENABLED, {4'b0, mbc1});
        write_reg(mbc1_pkg::CFG_BATTERY_PRESENT, {4'b0, batt});
        write_reg(mbc1_pkg::CFG_RAM_BANK_COUNT, banks);
        cfg_valid = 1'b0;
    endtask

    function logic [15:0] xram_addr(logic [15:0] a);
        // half the time a few offsets only, so RAM reads hit earlier writes
        return {3'b101, ($urandom_range(1) != 0) ? {9'b0, a[3:0]} : a[12:0]};
    endfunction

    task automatic random_item();
        int          r;
        int          sub;
        logic [1:0]  kind;
        logic [15:0] a;
        logic [7:0]  v;
        logic [16:0] la;
        r   = $urandom_range(99);
        sub = $urandom_range(9);
        a   = 16'($urandom);
        v   = 8'($urandom);
        la  = 17'($urandom);
        if (r < 4)
            kind = KIND_UNKNOWN;
        else if (r < 22)
            kind = mbc1_pkg::KIND_LOAD;
        else if (r < 60)
        begin
            kind = mbc1_pkg::KIND_WRITE;
            case (sub)
                0:
                begin
                    a = {3'b000, a[12:0]};
                    if ($urandom_range(9) < 6)
                        v[3:0] = mbc1_pkg::RAM_EN_KEY;
                end
                1:
                begin
                    a = {3'b001, a[12:0]};
                    if ($urandom_range(3) == 0)
                        v = ($urandom_range(1) != 0) ? 8'h00 : 8'h20;
                end
                2: a = {3'b010, a[12:0]};
                3: a = {3'b011, a[12:0]};
                9: ;
                default: a = xram_addr(a);
            endcase
        end
        else
        begin
            kind = mbc1_pkg::KIND_READ;
            case (sub)
                4, 5:    a = {2'b00, a[13:0]};
                6, 7:    a = {2'b01, a[13:0]};
                8, 9:    ;
                default: a = xram_addr(a);
            endcase
        end
        do_item(kind, a, v, la);
    endtask

    task automatic run_phase(logic mbc1, logic batt, logic [4:0] banks,
                             bit steady, bit hold);
        configure(mbc1, batt, banks);
        no_idle = steady;
        if (hold)
            hold_req = 1'b1;
        repeat (PHASE_ITEMS) random_item();
        no_idle = 1'b0;
    endtask

    initial
    begin
        cart = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, bank quirks, RAM gating, mode behavior
        configure(1'b1, 1'b1, 5'd4);
        do_item(mbc1_pkg::KIND_LOAD, 16'hFFFF, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_LOAD, 16'h0000, 8'hFF, 17'h1FFFF);
        do_item(mbc1_pkg::KIND_READ, 16'h0000, 8'hFF, 17'h1FFFF);
        do_item(mbc1_pkg::KIND_WRITE, 16'h2000, 8'h00, 17'h00000);  // bank 0 turns into 1
        do_item(mbc1_pkg::KIND_READ, 16'h7FFF, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'h3FFF, 8'h20, 17'h00000);  // 0x20 masks to bank 0
        do_item(mbc1_pkg::KIND_READ, 16'h4000, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'h2000, 8'hFF, 17'h00000);  // bank 31, offset wraps
        do_item(mbc1_pkg::KIND_READ, 16'hFFFF, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_READ, 16'h8000, 8'h00, 17'h00000);  // outside windows, via ROM bank
        do_item(mbc1_pkg::KIND_READ, 16'hA000, 8'h00, 17'h00000);  // RAM still disabled
        do_item(mbc1_pkg::KIND_WRITE, 16'h0000, 8'hFA, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'hA000, 8'h5A, 17'h00000);
        do_item(mbc1_pkg::KIND_READ, 16'hA000, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'h6000, 8'hFF, 17'h00000);  // mode 1
        do_item(mbc1_pkg::KIND_WRITE, 16'h5FFF, 8'hFF, 17'h00000);  // select 3, follows
        do_item(mbc1_pkg::KIND_WRITE, 16'hBFFF, 8'hFF, 17'h00000);
        do_item(mbc1_pkg::KIND_READ, 16'hBFFF, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'h7FFF, 8'hFE, 17'h00000);  // mode 0, bank kept
        do_item(mbc1_pkg::KIND_WRITE, 16'h4000, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_READ, 16'hBFFF, 8'h00, 17'h00000);
        do_item(mbc1_pkg::KIND_WRITE, 16'h1FFF, 8'h0B, 17'h00000);  // RAM disabled again
        do_item(mbc1_pkg::KIND_READ, 16'hA123, 8'h00, 17'h00000);
        do_item(KIND_UNKNOWN, 16'hFFFF, 8'hFF, 17'h1FFFF);
        do_item(mbc1_pkg::KIND_WRITE, 16'hFFFF, 8'h55, 17'h00000);

        run_phase(1'b1, 1'b1, 5'd4,  1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 5'd2,  1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 5'd16, 1'b0, 1'b0);   // flat ROM, writes dropped
        run_phase(1'b1, 1'b1, 5'd0,  1'b0, 1'b1);   // no RAM fitted, long output stall
        run_phase(1'b1, 1'b1, 5'd16, 1'b1, 1'b0);   // no gaps on either side
        run_phase(1'b1, 1'b0, 5'd1,  1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 5'd3,  1'b0, 1'b1);
        run_phase(1'b1, 1'b1, 5'd3,  1'b0, 1'b0);

        settle();
        if (cart.errors == 0 && cart.expected_q.size() == 0)
            $display("mbc1_bank_controller_core test passed");
        else
            $display("mbc1_bank_controller_core test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mbc1_pkg.sv
sv/mbc1_ram.sv
sv/mbc1_bank_controller_core.sv
bench/testbench.sv
